// File: sv/bvf_pkg.sv
// Shared types, constants and command structures of the beam line vertex filter.
package bvf_pkg;

  localparam int MAX_TRACKS_DEF = 64;
  localparam int CFG_W          = 31;
  localparam int CNT_W          = 7;
  localparam int DIV_STEPS      = 35;

  localparam logic [CFG_W-1:0] THR_RST = 31'd196608;
  localparam logic [CFG_W-1:0] RAD_RST = 31'd1638400;
  localparam logic [CNT_W-1:0] MAX_RST = 7'd5;

  typedef enum logic [1:0] {
    REG_LINE_DIST  = 2'd0,
    REG_RADIUS     = 2'd1,
    REG_MAX_CAND   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic               event_start;
    logic               has_fit;
    logic [7:0]         track_id;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } bvf_in_t;

  typedef struct packed {
    logic [7:0]         out_track_id;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } bvf_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_FIN
  } state_t;

  // Multiplier operand sources
  typedef enum logic [3:0] {
    OP_PX, OP_PY, OP_EX, OP_EY, OP_EZ, OP_THR, OP_RAD,
    OP_S, OP_C, OP_P, OP_T2, OP_R4
  } op_t;

  // Accumulator store targets
  typedef enum logic [3:0] {
    ST_S, ST_PR0, ST_PR1, ST_PR2, ST_PR3, ST_T2, ST_R4,
    ST_C2, ST_LT1, ST_LT2
  } st_dst_t;

  typedef enum logic [1:0] {
    V_X, V_Y, V_Z
  } vdst_t;

  typedef struct packed {
    logic    load;
    logic    mac_en;
    logic    mac_clr;
    op_t     a_sel;
    logic    a_hi;
    op_t     b_sel;
    logic    b_hi;
    logic [1:0] sh;
    logic    st_en;
    st_dst_t st_dst;
    logic    form_cp;
    logic    div_start;
    logic    div_step;
    logic    vwr_en;
    vdst_t   vdst;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic lt1;
    logic lt2;
  } status_t;

endpackage

// File: sv/bvf_ctrl.sv
// Controller: sequencer for the shared multiplier and divider, event bookkeeping.
module bvf_ctrl #(
  parameter int MAX_TRACKS = bvf_pkg::MAX_TRACKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      event_start,
  input  logic                      has_fit,
  input  logic [7:0]                track_id,
  input  logic [bvf_pkg::CNT_W-1:0] max_cand,
  input  logic                      out_stall,
  output logic                      out_valid,
  output bvf_pkg::cmd_t             cmd,
  input  bvf_pkg::status_t          st
);
  import bvf_pkg::*;

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int PC_W  = 6;
  localparam int DC_W  = $clog2(DIV_STEPS);
  localparam logic [PC_W-1:0] PC_SZERO  = 6'd8;
  localparam logic [PC_W-1:0] PC_DECIDE = 6'd23;
  localparam logic [PC_W-1:0] PC_LAST   = 6'd33;

  state_t                state_r, state_nxt;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic [DC_W-1:0]       dcnt_r, dcnt_nxt;
  logic [MAX_TRACKS-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept, in_range, pass, run;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign in_range  = ({1'b0, track_id} < 9'(MAX_TRACKS));
  assign run       = has_fit && in_range;
  assign pass      = st.lt1 && st.lt2 && !seen_r[idx_r] && (count_r < max_cand);

  function automatic cmd_t mul(input cmd_t c, input op_t a, input logic ah, input op_t b,
                               input logic bh, input logic clr, input logic [1:0] sh);
    cmd_t r;
    r         = c;
    r.mac_en  = 1'b1;
    r.mac_clr = clr;
    r.a_sel   = a;
    r.a_hi    = ah;
    r.b_sel   = b;
    r.b_hi    = bh;
    r.sh      = sh;
    return r;
  endfunction

  function automatic cmd_t store(input cmd_t c, input st_dst_t d);
    cmd_t r;
    r        = c;
    r.st_en  = 1'b1;
    r.st_dst = d;
    return r;
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && run) state_nxt = S_CALC;
      end
      S_CALC: begin
        if (pc_r == PC_SZERO && st.s_zero) state_nxt = S_IDLE;
        else if (pc_r == PC_DECIDE && !pass) state_nxt = S_IDLE;
        else if (pc_r == 6'd24 || pc_r == 6'd28 || pc_r == 6'd32) state_nxt = S_DIV;
        else if (pc_r == PC_LAST) state_nxt = S_FIN;
      end
      S_DIV: begin
        if (dcnt_r == DC_W'(DIV_STEPS - 1)) state_nxt = S_CALC;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd        = '0;
    cmd.a_sel  = OP_PX;
    cmd.b_sel  = OP_PX;
    cmd.st_dst = ST_S;
    cmd.vdst   = V_X;
    case (state_r)
      S_IDLE: cmd.load = accept;
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.out_load = !out_valid_r || !out_stall;
      S_CALC: begin
        case (pc_r)
          6'd0:  cmd = mul(cmd, OP_EX, 1'b0, OP_EX, 1'b0, 1'b1, 2'd0);
          6'd1:  cmd = mul(cmd, OP_EY, 1'b0, OP_EY, 1'b0, 1'b0, 2'd0);
          6'd2:  cmd = mul(cmd, OP_PX, 1'b0, OP_EY, 1'b0, 1'b1, 2'd0);
          6'd3:  cmd = mul(store(cmd, ST_S), OP_PY, 1'b0, OP_EX, 1'b0, 1'b1, 2'd0);
          6'd4:  cmd = mul(store(cmd, ST_PR0), OP_PX, 1'b0, OP_EX, 1'b0, 1'b1, 2'd0);
          6'd5:  cmd = mul(store(cmd, ST_PR1), OP_PY, 1'b0, OP_EY, 1'b0, 1'b1, 2'd0);
          6'd6:  cmd = mul(store(cmd, ST_PR2), OP_THR, 1'b0, OP_THR, 1'b0, 1'b1, 2'd0);
          6'd7:  cmd = mul(store(cmd, ST_PR3), OP_RAD, 1'b0, OP_RAD, 1'b0, 1'b1, 2'd0);
          6'd8: begin
            cmd         = store(cmd, ST_T2);
            cmd.form_cp = 1'b1;
          end
          6'd9:  cmd = mul(store(cmd, ST_R4), OP_C, 1'b0, OP_C, 1'b0, 1'b1, 2'd0);
          6'd10: cmd = mul(cmd, OP_C, 1'b0, OP_C, 1'b1, 1'b0, 2'd1);
          6'd11: cmd = mul(cmd, OP_C, 1'b1, OP_C, 1'b0, 1'b0, 2'd1);
          6'd12: cmd = mul(cmd, OP_C, 1'b1, OP_C, 1'b1, 1'b0, 2'd2);
          6'd13: cmd = mul(cmd, OP_T2, 1'b0, OP_S, 1'b0, 1'b1, 2'd0);
          6'd14: cmd = mul(store(cmd, ST_C2), OP_T2, 1'b0, OP_S, 1'b1, 1'b0, 2'd1);
          6'd15: cmd = mul(cmd, OP_T2, 1'b1, OP_S, 1'b0, 1'b0, 2'd1);
          6'd16: cmd = mul(cmd, OP_T2, 1'b1, OP_S, 1'b1, 1'b0, 2'd2);
          6'd17: cmd = mul(cmd, OP_R4, 1'b0, OP_S, 1'b0, 1'b1, 2'd0);
          6'd18: cmd = mul(store(cmd, ST_LT1), OP_R4, 1'b0, OP_S, 1'b1, 1'b0, 2'd1);
          6'd19: cmd = mul(cmd, OP_R4, 1'b1, OP_S, 1'b0, 1'b0, 2'd1);
          6'd20: cmd = mul(cmd, OP_R4, 1'b1, OP_S, 1'b1, 1'b0, 2'd2);
          6'd21: cmd = mul(cmd, OP_EY, 1'b0, OP_C, 1'b0, 1'b1, 2'd0);
          6'd22: cmd = mul(store(cmd, ST_LT2), OP_EY, 1'b0, OP_C, 1'b1, 1'b0, 2'd1);
          6'd24: cmd.div_start = 1'b1;
          6'd25: begin
            cmd        = mul(cmd, OP_EX, 1'b0, OP_C, 1'b0, 1'b1, 2'd0);
            cmd.vwr_en = 1'b1;
            cmd.vdst   = V_X;
          end
          6'd26: cmd = mul(cmd, OP_EX, 1'b0, OP_C, 1'b1, 1'b0, 2'd1);
          6'd28: cmd.div_start = 1'b1;
          6'd29: begin
            cmd        = mul(cmd, OP_EZ, 1'b0, OP_P, 1'b0, 1'b1, 2'd0);
            cmd.vwr_en = 1'b1;
            cmd.vdst   = V_Y;
          end
          6'd30: cmd = mul(cmd, OP_EZ, 1'b0, OP_P, 1'b1, 1'b0, 2'd1);
          6'd32: cmd.div_start = 1'b1;
          6'd33: begin
            cmd.vwr_en = 1'b1;
            cmd.vdst   = V_Z;
          end
          default: cmd.mac_en = 1'b0;
        endcase
      end
      default: cmd.load = 1'b0;
    endcase
  end

  // Program counter, divider count, event bookkeeping and result flag
  always_comb begin
    pc_nxt        = pc_r;
    dcnt_nxt      = dcnt_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        pc_nxt = '0;
        if (accept) begin
          idx_nxt = track_id[IDX_W-1:0];
          if (event_start) begin
            seen_nxt  = '0;
            count_nxt = '0;
          end
        end
      end
      S_CALC: begin
        pc_nxt   = pc_r + 1'b1;
        dcnt_nxt = '0;
        if (pc_r == PC_DECIDE && pass) begin
          seen_nxt[idx_r] = 1'b1;
          count_nxt       = count_r + 1'b1;
        end
      end
      S_DIV:  dcnt_nxt = dcnt_r + 1'b1;
      S_FIN: begin
        if (!out_valid_r || !out_stall) out_valid_nxt = 1'b1;
      end
      default: pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      dcnt_r      <= '0;
      seen_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      dcnt_r      <= dcnt_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/bvf_dp.sv
// Datapath: operand registers, shared 32x32 multiply-accumulate, compares and divider.
module bvf_dp (
  input  logic                      clk,
  input  bvf_pkg::bvf_in_t          in_data,
  input  logic [bvf_pkg::CFG_W-1:0] thr,
  input  logic [bvf_pkg::CFG_W-1:0] rad,
  input  bvf_pkg::cmd_t             cmd,
  output bvf_pkg::status_t          st,
  output bvf_pkg::bvf_out_t         out_data
);
  import bvf_pkg::*;

  localparam int QW = DIV_STEPS;
  localparam logic [QW-1:0] QCAP = QW'(1) << (QW - 1);

  typedef struct packed {
    logic       en;
    logic       clr;
    logic [1:0] sh;
  } pacc_t;

  // Operand registers
  logic [7:0]         id_r;
  logic               spx_r, spy_r, sex_r, sey_r, sez_r;
  logic [31:0]        mpx_r, mpy_r, mex_r, mey_r, mez_r;
  logic signed [31:0] pz_r;
  logic [63:0]        s_r, t2_r, r4_r, mc_r, mp_r;
  logic [63:0]        pr_r [4];
  logic               sc_r, sp_r;
  logic [127:0]       c2_r;
  logic               lt1_r, lt2_r;
  // Multiply-accumulate
  logic [63:0]        prod_r;
  pacc_t              pacc_r;
  logic [127:0]       acc_r, acc_nxt, addend;
  logic [31:0]        opa, opb;
  // Divider
  logic [63:0]        rem_r;
  logic [QW-1:0]      nlo_r, q_r, q_fin;
  logic               cap_r;
  logic [64:0]        trial;
  logic               ge;
  // Vertex and result
  logic signed [31:0] vx_r, vy_r, vz_r, vsat;
  logic               vneg;
  logic signed [36:0] vmag, vval;
  bvf_out_t           out_r;
  logic               c_s, p_s;
  logic [63:0]        c_m, p_m;

  function automatic logic [31:0] mag32(input logic [31:0] raw);
    return raw[31] ? (32'd0 - raw) : raw;
  endfunction

  // Sign-magnitude add; a zero result is positive
  function automatic logic [64:0] sm_add(input logic sa, input logic [63:0] ma,
                                         input logic sb, input logic [63:0] mb);
    logic        s;
    logic [63:0] m;
    if (sa == sb) begin
      m = ma + mb;
      s = sa;
    end else if (ma >= mb) begin
      m = ma - mb;
      s = sa;
    end else begin
      m = mb - ma;
      s = sb;
    end
    if (m == '0) s = 1'b0;
    return {s, m};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] src(input op_t op, input logic [63:0] s, input logic [63:0] c,
                                      input logic [63:0] p, input logic [63:0] t2,
                                      input logic [63:0] r4);
    case (op)
      OP_PX:   return {32'd0, mpx_r};
      OP_PY:   return {32'd0, mpy_r};
      OP_EX:   return {32'd0, mex_r};
      OP_EY:   return {32'd0, mey_r};
      OP_EZ:   return {32'd0, mez_r};
      OP_THR:  return {33'd0, thr};
      OP_RAD:  return {33'd0, rad};
      OP_S:    return s;
      OP_C:    return c;
      OP_P:    return p;
      OP_T2:   return t2;
      OP_R4:   return r4;
      default: return '0;
    endcase
  endfunction

  assign st.s_zero = (s_r == '0);
  assign st.lt1    = lt1_r;
  assign st.lt2    = lt2_r;
  assign out_data  = out_r;

  // Select operand halves
  always_comb begin
    logic [63:0] a64, b64;
    a64 = src(cmd.a_sel, s_r, mc_r, mp_r, t2_r, r4_r);
    b64 = src(cmd.b_sel, s_r, mc_r, mp_r, t2_r, r4_r);
    opa = cmd.a_hi ? a64[63:32] : a64[31:0];
    opb = cmd.b_hi ? b64[63:32] : b64[31:0];
  end

  // Align the registered product and accumulate
  always_comb begin
    case (pacc_r.sh)
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      2'd2:    addend = {prod_r, 64'd0};
      default: addend = {64'd0, prod_r};
    endcase
    acc_nxt = (pacc_r.clr ? 128'd0 : acc_r) + addend;
  end

  // Cross products into C and P
  assign {c_s, c_m} = sm_add(spx_r ^ sey_r, pr_r[0], !(spy_r ^ sex_r), pr_r[1]);
  assign {p_s, p_m} = sm_add(spx_r ^ sex_r, pr_r[2], spy_r ^ sey_r, pr_r[3]);

  // One restoring divide step
  assign trial = {rem_r, nlo_r[QW-1]};
  assign ge    = (trial >= {1'b0, s_r});
  assign q_fin = (cap_r || q_r > QCAP) ? QCAP : q_r;

  // Sign and saturate the quotient for the selected vertex field
  always_comb begin
    case (cmd.vdst)
      V_X:     vneg = sey_r ^ sc_r;
      V_Y:     vneg = !(sex_r ^ sc_r);
      default: vneg = sez_r ^ sp_r;
    endcase
    if (cmd.vdst == V_Z) vmag = {2'b00, q_fin};
    else                 vmag = {3'b000, q_fin[QW-1:1]};
    vval = vneg ? -vmag : vmag;
    if (cmd.vdst == V_Z) vval = 37'(pz_r) - vval;
    vsat = sat32(vval);
  end

  always_ff @(posedge clk) begin
    // Latch the track
    if (cmd.load) begin
      id_r  <= in_data.track_id;
      spx_r <= in_data.point_x[31];
      spy_r <= in_data.point_y[31];
      sex_r <= in_data.dir_x[31];
      sey_r <= in_data.dir_y[31];
      sez_r <= in_data.dir_z[31];
      mpx_r <= mag32(in_data.point_x);
      mpy_r <= mag32(in_data.point_y);
      mex_r <= mag32(in_data.dir_x);
      mey_r <= mag32(in_data.dir_y);
      mez_r <= mag32(in_data.dir_z);
      pz_r  <= in_data.point_z;
    end
    // Multiply into the product register, then accumulate from it in the next cycle
    prod_r     <= {32'd0, opa} * {32'd0, opb};
    pacc_r.en  <= cmd.mac_en;
    pacc_r.clr <= cmd.mac_clr;
    pacc_r.sh  <= cmd.sh;
    if (pacc_r.en) acc_r <= acc_nxt;
    // Store accumulator results
    if (cmd.st_en) begin
      case (cmd.st_dst)
        ST_S:    s_r    <= acc_r[63:0];
        ST_PR0:  pr_r[0] <= acc_r[63:0];
        ST_PR1:  pr_r[1] <= acc_r[63:0];
        ST_PR2:  pr_r[2] <= acc_r[63:0];
        ST_PR3:  pr_r[3] <= acc_r[63:0];
        ST_T2:   t2_r   <= acc_r[63:0];
        ST_R4:   r4_r   <= {acc_r[61:0], 2'b00};
        ST_C2:   c2_r   <= acc_r;
        ST_LT1:  lt1_r  <= (c2_r < acc_r);
        ST_LT2:  lt2_r  <= (c2_r < acc_r);
        default: lt2_r  <= lt2_r;
      endcase
    end
    if (cmd.form_cp) begin
      sc_r <= c_s;
      mc_r <= c_m;
      sp_r <= p_s;
      mp_r <= p_m;
    end
    // Divider: start with the high part, then one quotient bit per cycle
    if (cmd.div_start) begin
      cap_r <= (acc_r[127:QW] >= {{(128-QW-64){1'b0}}, s_r});
      rem_r <= acc_r[QW+63:QW];
      nlo_r <= acc_r[QW-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 64'(trial - {1'b0, s_r}) : trial[63:0];
      nlo_r <= {nlo_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
    end
    if (cmd.vwr_en) begin
      case (cmd.vdst)
        V_X:     vx_r <= vsat;
        V_Y:     vy_r <= vsat;
        default: vz_r <= vsat;
      endcase
    end
    // Hold the result for the output transfer
    if (cmd.out_load) begin
      out_r.out_track_id <= id_r;
      out_r.vertex_x     <= vx_r;
      out_r.vertex_y     <= vy_r;
      out_r.vertex_z     <= vz_r;
    end
  end

endmodule

// File: sv/beam_line_vertex_filter.sv
// Top level: configuration registers, controller and datapath of the vertex filter.
// A track that passes runs 34 program steps, three divides and one output load before
//   out_valid rises; one track in flight, the next taken once the block is idle again.
// A track without a fit or with an out-of-range ID is taken without starting work; S = 0
//   ends the work at the S test, a failed distance or bookkeeping test at the decision step.
// Rate is set by the single shared 32x32 multiplier and the one bit per cycle divider.
// Reset: configuration to defaults, seen marks and emitted count cleared, no result.
module beam_line_vertex_filter #(
  parameter int MAX_TRACKS = bvf_pkg::MAX_TRACKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bvf_pkg::bvf_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bvf_pkg::bvf_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bvf_pkg::CFG_W-1:0] cfg_data
);
  import bvf_pkg::*;

  logic [CFG_W-1:0] thr_r, rad_r;
  logic [CNT_W-1:0] max_r;
  cmd_t             cmd;
  status_t          st;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
      rad_r <= RAD_RST;
      max_r <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_DIST: thr_r <= cfg_data;
        REG_RADIUS:    rad_r <= cfg_data;
        REG_MAX_CAND:  max_r <= cfg_data[CNT_W-1:0];
        default:       max_r <= max_r;
      endcase
    end
  end

  bvf_ctrl #(.MAX_TRACKS(MAX_TRACKS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .event_start (in_data.event_start),
    .has_fit     (in_data.has_fit),
    .track_id    (in_data.track_id),
    .max_cand    (max_r),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .st          (st)
  );

  bvf_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .thr      (thr_r),
    .rad      (rad_r),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

// File: sv/bvf_checker.sv
// Port-level checks of the vertex filter and their binding to the top level.
module bvf_checker #(
  parameter int MAX_TRACKS = bvf_pkg::MAX_TRACKS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input bvf_pkg::bvf_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input bvf_pkg::bvf_out_t         out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // A track to be worked on makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.has_fit && ({1'b0, in_data.track_id} < 9'(MAX_TRACKS))
    |=> in_stall)
    else $error("fitted track did not start work");

  // A track without a fit is dropped at once
  a_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.has_fit |=> !in_stall)
    else $error("unfitted track held the block");

  // A new result only comes out of a busy block
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind beam_line_vertex_filter bvf_checker #(.MAX_TRACKS(MAX_TRACKS)) u_bvf_checker (.*);

// File: test/testbench.sv
// Self-checking testbench of the beam line vertex filter: stimulus, prediction and checks.
`timescale 1ns / 100ps

module testbench;
  import bvf_pkg::*;

  localparam int NTRK      = MAX_TRACKS_DEF;
  localparam int SETTLE    = 160;      // a margin over the track latency
  localparam int LIMIT     = 1000000;
  localparam int LONG_HOLD = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  bvf_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  bvf_out_t          out_data;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Predictor copy of configuration and bookkeeping
  logic [30:0] thr_cfg;
  logic [30:0] rad_cfg;
  logic [6:0]  maxc_cfg;
  bit          seen_id [NTRK];
  logic [6:0]  emitted_cnt;

  bvf_out_t vertex_q[$];
  int       err_cnt = 0;
  int       track_cnt;
  int       vertex_cnt = 0;
  int       cfg_cnt;
  int       cycle_cnt = 0;
  bit       tx_idle_en;
  bit       rx_idle_en;
  bit       long_hold_req;
  bit       long_hold_done;

  beam_line_vertex_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Quotient of magnitudes, capped at 2^34
  function automatic logic [127:0] quot_cap(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q;
    q = n / d;
    if (q > (128'd1 << 34)) q = 128'd1 << 34;
    return q;
  endfunction

  // Work out the vertex of one track and advance the bookkeeping
  function automatic bit predict_vertex(input bvf_in_t t, output bvf_out_t r);
    logic signed [127:0] px, py, pz, ex, ey, ez, cv, pv, sq;
    logic [127:0] s, mc, mp, mex, mey, mez, q;
    logic sc, sp;
    r = '0;
    if (t.event_start) begin
      foreach (seen_id[i]) seen_id[i] = 1'b0;
      emitted_cnt = '0;
    end
    if (!t.has_fit) return 1'b0;
    if (t.track_id >= NTRK) return 1'b0;
    px = $signed(t.point_x);
    py = $signed(t.point_y);
    pz = $signed(t.point_z);
    ex = $signed(t.dir_x);
    ey = $signed(t.dir_y);
    ez = $signed(t.dir_z);
    s = ex * ex + ey * ey;
    if (s == 0) return 1'b0;
    cv = ey * px - ex * py;
    pv = ex * px + ey * py;
    sc = cv < 0;
    sp = pv < 0;
    mc = sc ? -cv : cv;
    mp = sp ? -pv : pv;
    mex = ex < 0 ? -ex : ex;
    mey = ey < 0 ? -ey : ey;
    mez = ez < 0 ? -ez : ez;
    if (!(mc * mc < 128'(thr_cfg) * 128'(thr_cfg) * s)) return 1'b0;
    if (!(mc * mc < 128'd4 * 128'(rad_cfg) * 128'(rad_cfg) * s)) return 1'b0;
    if (seen_id[t.track_id]) return 1'b0;
    if (emitted_cnt >= maxc_cfg) return 1'b0;
    seen_id[t.track_id] = 1'b1;
    emitted_cnt = emitted_cnt + 7'd1;
    r.out_track_id = t.track_id;
    q = quot_cap(mey * mc, s) >> 1;
    sq = $signed(q);
    r.vertex_x = clamp32((t.dir_y[31] ^ sc) ? -sq : sq);
    q = quot_cap(mex * mc, s) >> 1;
    sq = $signed(q);
    r.vertex_y = clamp32(!(t.dir_x[31] ^ sc) ? -sq : sq);
    q = quot_cap(mez * mp, s);
    sq = $signed(q);
    r.vertex_z = clamp32(pz - ((t.dir_z[31] ^ sp) ? -sq : sq));
    return 1'b1;
  endfunction

  function automatic bvf_in_t mk_track(input int es, input int fit, input int id,
                                       input int px, input int py, input int pz,
                                       input int dx, input int dy, input int dz);
    bvf_in_t t;
    t.event_start = es[0];
    t.has_fit     = fit[0];
    t.track_id    = id[7:0];
    t.point_x     = px;
    t.point_y     = py;
    t.point_z     = pz;
    t.dir_x       = dx;
    t.dir_y       = dy;
    t.dir_z       = dz;
    return t;
  endfunction

  // Near-beam track with random content, or pure noise
  function automatic bvf_in_t rand_track(input bit shaped);
    bvf_in_t t;
    if (!shaped) begin
      {t.event_start, t.has_fit} = 2'($urandom_range(0, 3));
      t.track_id = 8'($urandom());
      t.point_x  = $urandom();
      t.point_y  = $urandom();
      t.point_z  = $urandom();
      t.dir_x    = $urandom();
      t.dir_y    = $urandom();
      t.dir_z    = $urandom();
      return t;
    end
    t.event_start = ($urandom_range(0, 24) == 0);
    t.has_fit     = ($urandom_range(0, 15) != 0);
    t.track_id    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(64, 255))
                                                : 8'($urandom_range(0, 63));
    t.point_x     = int'($urandom_range(0, 524288)) - 262144;
    t.point_y     = int'($urandom_range(0, 524288)) - 262144;
    t.point_z     = $urandom();
    t.dir_x       = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(0, 131072)) - 65536;
    t.dir_y       = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(0, 131072)) - 65536;
    t.dir_z       = $urandom();
    return t;
  endfunction

  // Register write, mirrored into the predictor
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_DIST: thr_cfg = val;
      REG_RADIUS:    rad_cfg = val;
      REG_MAX_CAND:  maxc_cfg = val[6:0];
      default: ;
    endcase
    cfg_cnt++;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [30:0] thr, input logic [30:0] rad, input logic [6:0] mc);
    write_reg(REG_LINE_DIST, thr);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_MAX_CAND, {24'd0, mc});
  endtask

  // Offer one track, hold it until the transfer, record its expected vertex
  task automatic send_track(input bvf_in_t t);
    bvf_out_t v;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    if (predict_vertex(t, v)) vertex_q = {vertex_q, v};
    track_cnt++;
    @(posedge clk);
  endtask

  // Wait for every vertex, then let the block finish any silent work
  task automatic drain;
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_done = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each vertex transfer with the oldest expectation
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, out_data);
        err_cnt++;
      end else begin
        bvf_out_t e;
        e = vertex_q.pop_front();
        vertex_cnt++;
        if (e.out_track_id !== out_data.out_track_id) begin
          $display("%0t: track_id expected %0d actual %0d", $time, e.out_track_id,
                   out_data.out_track_id);
          err_cnt++;
        end
        if (e.vertex_x !== out_data.vertex_x) begin
          $display("%0t: vertex_x expected %h actual %h", $time, e.vertex_x, out_data.vertex_x);
          err_cnt++;
        end
        if (e.vertex_y !== out_data.vertex_y) begin
          $display("%0t: vertex_y expected %h actual %h", $time, e.vertex_y, out_data.vertex_y);
          err_cnt++;
        end
        if (e.vertex_z !== out_data.vertex_z) begin
          $display("%0t: vertex_z expected %h actual %h", $time, e.vertex_z, out_data.vertex_z);
          err_cnt++;
        end
      end
    end
  end

  // Corner cases at default settings, then at the widest distance and radius settings
  task automatic test_directed;
    send_track(mk_track(1, 0, 3, 0, 65536, 0, 65536, 0, 0));
    send_track(mk_track(0, 1, 3, 0, 65536, 100, 65536, 0, 65536));
    send_track(mk_track(0, 1, 3, 0, 65536, 100, 65536, 0, 65536));
    send_track(mk_track(0, 1, 63, 65536, 0, -5, 0, 65536, -65536));
    send_track(mk_track(0, 1, 64, 0, 0, 0, 65536, 0, 0));
    send_track(mk_track(0, 1, 255, 0, 0, 0, 65536, 0, 0));
    send_track(mk_track(0, 1, 7, 0, 0, 0, 0, 0, 65536));
    send_track(mk_track(0, 1, 8, 1 << 20, 0, 0, 0, 65536, 0));
    for (int i = 10; i < 14; i++)
      send_track(mk_track(0, 1, i, i * 1000, -i * 900, i, 3000, 7000, -65536));
    send_track(mk_track(1, 1, 3, 0, 65536, 100, 65536, 0, 65536));
    drain();
    set_filter(31'h7fffffff, 31'h7fffffff, 7'd64);
    send_track(mk_track(1, 1, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        1, 32'h80000000, 32'h7fffffff));
    send_track(mk_track(0, 1, 1, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 1, 32'h80000000));
    send_track(mk_track(0, 1, 2, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        1, 1, 32'h7fffffff));
    send_track(mk_track(0, 1, 4, 32'h80000000, 32'h80000000, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_track(mk_track(0, 1, 5, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 1));
    drain();
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++)
      send_track(rand_track($urandom_range(0, 9) != 0));
  endtask

  // Sweep of settings, extremes and random values
  task automatic test_settings;
    set_filter(31'd0, 31'h7fffffff, 7'd64);
    random_run(40);
    drain();
    set_filter(31'h7fffffff, 31'd0, 7'd64);
    random_run(40);
    drain();
    set_filter(31'h7fffffff, 31'h7fffffff, 7'd0);
    random_run(40);
    drain();
    set_filter(31'd262144, 31'd1638400, 7'd127);
    random_run(120);
    drain();
    for (int k = 0; k < 3; k++) begin
      set_filter(31'($urandom_range(65536, 393216)), 31'($urandom_range(0, 32'h7fffffff)),
                 7'($urandom_range(0, 127)));
      random_run(60);
      drain();
    end
  endtask

  // Long receiver hold while tracks keep coming, then a full pause
  task automatic test_backpressure;
    set_filter(31'd327680, 31'd1638400, 7'd64);
    long_hold_req = 1'b1;
    random_run(30);
    drain();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_streaming;
    set_filter(31'd196608, 31'd1638400, 7'd5);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_run(330);
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_LINE_DIST;
    cfg_data      = '0;
    track_cnt     = 0;
    cfg_cnt       = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    long_hold_req = 1'b0;
    thr_cfg       = THR_RST;
    rad_cfg       = RAD_RST;
    maxc_cfg      = MAX_RST;
    emitted_cnt   = '0;
    foreach (seen_id[i]) seen_id[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_settings();
    test_backpressure();
    test_streaming();

    $display("Run covered %0d tracks, %0d vertices checked, %0d register writes.",
             track_cnt, vertex_cnt, cfg_cnt);
    $display("Settings swept through zero, maximum and random limits, with stalls on both sides.");
    if (err_cnt == 0 && vertex_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bvf_pkg.sv
sv/bvf_ctrl.sv
sv/bvf_dp.sv
sv/beam_line_vertex_filter.sv
sv/bvf_checker.sv
test/testbench.sv
